### hdl/dmxtx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmxtx_pkg;

   // Host actions carried in the input word
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_SET  = 2'd1;
   localparam logic [1:0] ACT_GET  = 2'd2;
   localparam logic [1:0] ACT_SEND = 2'd3;

   // Line control codes
   localparam logic [1:0] LINE_LOW  = 2'd0;
   localparam logic [1:0] LINE_HIGH = 2'd1;
   localparam logic [1:0] LINE_UART = 2'd2;

   // Control register indexes
   localparam logic [1:0] CSR_CYCLES_PER_US   = 2'd0;
   localparam logic [1:0] CSR_BREAK_LENGTH_US = 2'd1;
   localparam logic [1:0] CSR_MAB_LENGTH_US   = 2'd2;

   // Control register reset values
   localparam logic [7:0] CYCLES_PER_US_RESET   = 8'd16;
   localparam logic [9:0] BREAK_LENGTH_US_RESET = 10'd120;
   localparam logic [7:0] MAB_LENGTH_US_RESET   = 8'd12;

   // DMX start code held in slot 0
   localparam logic [7:0] START_CODE = 8'h00;

   localparam int CHAN_W  = 10;
   localparam int DELAY_W = 18;

   typedef struct packed {
      logic [1:0]        action;
      logic [CHAN_W-1:0] channel;
      logic [7:0]        level;
      logic              tx_ready;
      logic              tx_complete;
   } req_type;

   typedef struct packed {
      logic [1:0] line_mode;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [7:0] read_level;
      logic       busy_res;
      logic       frame_done;
   } rsp_type;

   // Classified word passed from front to back
   typedef struct packed {
      logic [1:0]        action;
      logic              chan_ok;
      logic [CHAN_W-1:0] channel;
      logic [7:0]        level;
      logic              tx_ready;
      logic              tx_complete;
   } cmd_type;

endpackage

`default_nettype wire

### hdl/dmx512_frame_transmitter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake               Payload
// req      start / busy            req_data  (dmxtx_pkg::req_type)
// rsp      rsp_valid strobe        rsp_data  (dmxtx_pkg::rsp_type)
// csr      csr_valid / csr_ready   csr_index, csr_data
//
// Every accepted word gives one result via the queue and result stage;
// the front queue holds two words; the back end retires one word per
// cycle unless clearing. After reset the frame store is swept to zero,
// CHANNEL_COUNT+1 slots, busy held high; csr writes are taken meanwhile.
// Results cannot be stalled: each rsp word is shown for one cycle only.

module dmx512_frame_transmitter_core #(
   parameter int CHANNEL_COUNT = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dmxtx_pkg::req_type req_data,
   output logic                   rsp_valid,
   output dmxtx_pkg::rsp_type     rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [9:0]        csr_data
);

   logic               q_valid, q_pop, clearing;
   dmxtx_pkg::cmd_type q_cmd;

   dmxtx_front #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .hold     (clearing),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop)
   );

   dmxtx_back #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/dmxtx_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dmxtx_front #(
   parameter int CHANNEL_COUNT = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dmxtx_pkg::req_type req_data,
   input  wire logic              hold,
   output logic                   q_valid,
   output dmxtx_pkg::cmd_type     q_cmd,
   input  wire logic              q_pop
);

   localparam logic [dmxtx_pkg::CHAN_W-1:0] MAX_CHAN = dmxtx_pkg::CHAN_W'(CHANNEL_COUNT);

   dmxtx_pkg::cmd_type fifo_ff [2];
   logic [1:0]         count_ff, count_in;
   logic               wr_ptr_ff, rd_ptr_ff;
   logic               accept;
   dmxtx_pkg::cmd_type cmd;

   // Accept while the queue has room and the store is not being cleared
   assign busy   = (count_ff == 2'd2) || hold;
   assign accept = start && !busy;

   // Classify: decode action and check the channel range
   always_comb begin
      cmd.action      = req_data.action;
      cmd.chan_ok     = (req_data.channel != '0) && (req_data.channel <= MAX_CHAN);
      cmd.channel     = req_data.channel;
      cmd.level       = req_data.level;
      cmd.tx_ready    = req_data.tx_ready;
      cmd.tx_complete = req_data.tx_complete;
   end

   always_comb begin
      case ({accept, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // Two-entry queue toward the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) fifo_ff[wr_ptr_ff] <= cmd;
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = fifo_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !q_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue push not counted");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### hdl/dmxtx_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dmxtx_back #(
   parameter int CHANNEL_COUNT = 512
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [9:0]        csr_data,
   input  wire logic              q_valid,
   input  wire dmxtx_pkg::cmd_type q_cmd,
   output logic                   q_pop,
   output logic                   clearing,
   output logic                   rsp_valid,
   output dmxtx_pkg::rsp_type     rsp_data
);

   localparam int DEPTH = CHANNEL_COUNT + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = dmxtx_pkg::DELAY_W;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_BREAK = 3'd1;
   localparam logic [2:0] PH_MAB   = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_WAIT  = 3'd4;

   logic [7:0]    frame_mem [DEPTH];

   logic [7:0]    cycles_per_us_ff;
   logic [9:0]    break_length_us_ff;
   logic [7:0]    mab_length_us_ff;

   logic          clear_ff;
   logic [AW-1:0] clr_addr_ff;

   logic [2:0]    phase_ff, phase_in;
   logic [DW-1:0] delay_ff, delay_in;
   logic [AW-1:0] byte_idx_ff, byte_idx_in;
   logic [AW:0]   idx_sum;

   logic [DW-1:0] break_ticks, mab_ticks;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;
   logic [7:0]    rdata_ff;

   logic          txv, done, get_ok;
   logic [1:0]    line_mode;

   logic          rsp_valid_ff, txv_ff, done_ff, get_ok_ff, busy_res_ff;
   logic [1:0]    line_ff;

   assign csr_ready = 1'b1;
   assign clearing  = clear_ff;
   assign q_pop     = q_valid && !clear_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cycles_per_us_ff   <= dmxtx_pkg::CYCLES_PER_US_RESET;
         break_length_us_ff <= dmxtx_pkg::BREAK_LENGTH_US_RESET;
         mab_length_us_ff   <= dmxtx_pkg::MAB_LENGTH_US_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            dmxtx_pkg::CSR_CYCLES_PER_US:   cycles_per_us_ff   <= csr_data[7:0];
            dmxtx_pkg::CSR_BREAK_LENGTH_US: break_length_us_ff <= csr_data;
            dmxtx_pkg::CSR_MAB_LENGTH_US:   mab_length_us_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Tick counts for break and mark-after-break
   assign break_ticks = DW'(cycles_per_us_ff) * DW'(break_length_us_ff);
   assign mab_ticks   = DW'(cycles_per_us_ff) * DW'(mab_length_us_ff);

   assign idx_sum = {1'b0, byte_idx_ff} + (AW+1)'(1);

   // Execute one word: store access and frame sequencing
   always_comb begin
      phase_in    = phase_ff;
      delay_in    = delay_ff;
      byte_idx_in = byte_idx_ff;
      txv         = 1'b0;
      done        = 1'b0;
      get_ok      = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = q_cmd.channel[AW-1:0];
      mem_wdata   = q_cmd.level;
      mem_raddr   = byte_idx_ff;
      if (clear_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = dmxtx_pkg::START_CODE;
      end else if (q_pop) begin
         case (q_cmd.action)
            dmxtx_pkg::ACT_SET: begin
               mem_we = q_cmd.chan_ok;
            end
            dmxtx_pkg::ACT_GET: begin
               mem_raddr = q_cmd.channel[AW-1:0];
               get_ok    = q_cmd.chan_ok;
            end
            dmxtx_pkg::ACT_SEND: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in = PH_BREAK;
                  delay_in = break_ticks;
               end
            end
            default: begin
               case (phase_ff)
                  PH_IDLE: ;
                  PH_BREAK: begin
                     if (delay_ff <= DW'(1)) begin
                        phase_in = PH_MAB;
                        delay_in = mab_ticks;
                     end else begin
                        delay_in = delay_ff - DW'(1);
                     end
                  end
                  PH_MAB: begin
                     if (delay_ff <= DW'(1)) begin
                        phase_in    = PH_DATA;
                        delay_in    = '0;
                        byte_idx_in = '0;
                     end else begin
                        delay_in = delay_ff - DW'(1);
                     end
                  end
                  PH_DATA: begin
                     if (q_cmd.tx_ready) begin
                        txv         = 1'b1;
                        byte_idx_in = idx_sum[AW-1:0];
                        if (idx_sum == (AW+1)'(DEPTH)) phase_in = PH_WAIT;
                     end
                  end
                  PH_WAIT: begin
                     if (q_cmd.tx_complete) begin
                        phase_in    = PH_IDLE;
                        byte_idx_in = '0;
                        done        = 1'b1;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         endcase
      end
   end

   always_comb begin
      case (phase_in)
         PH_BREAK: line_mode = dmxtx_pkg::LINE_LOW;
         PH_MAB:   line_mode = dmxtx_pkg::LINE_HIGH;
         default:  line_mode = dmxtx_pkg::LINE_UART;
      endcase
   end

   // Frame store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= frame_mem[mem_raddr];
   end

   // Sequencer state and clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
         phase_ff    <= PH_IDLE;
         delay_ff    <= '0;
         byte_idx_ff <= '0;
      end else begin
         if (clear_ff) begin
            if (clr_addr_ff == AW'(DEPTH - 1)) clear_ff <= 1'b0;
            else                               clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         phase_ff    <= phase_in;
         delay_ff    <= delay_in;
         byte_idx_ff <= byte_idx_in;
      end
   end

   // Result stage, lines up with the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      line_ff     <= line_mode;
      txv_ff      <= txv;
      done_ff     <= done;
      get_ok_ff   <= get_ok;
      busy_res_ff <= (phase_in != PH_IDLE);
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.line_mode  = line_ff;
      rsp_data.tx_valid   = txv_ff;
      rsp_data.tx_byte    = txv_ff ? rdata_ff : 8'd0;
      rsp_data.read_level = get_ok_ff ? rdata_ff : 8'd0;
      rsp_data.busy_res   = busy_res_ff;
      rsp_data.frame_done = done_ff;
   end

`ifndef SYNTHESIS
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff) else $error("popped word gave no result");
   a_data_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> ({1'b0, byte_idx_ff} < (AW+1)'(DEPTH)))
      else $error("slot index beyond frame");
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> ($past(clr_addr_ff) == AW'(DEPTH - 1)))
      else $error("clearing pass ended early");
`endif

endmodule

`default_nettype wire

### dv/dmx512_frame_transmitter_core_tb.sv
`timescale 1ns / 1ps

module dmx512_frame_transmitter_core_tb;

   localparam int CHANNEL_COUNT = 512;
   localparam int STORE_SLOTS   = CHANNEL_COUNT + 1;

   // index past the register list, writes to it are dropped
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef enum logic [2:0] {
      P_IDLE,
      P_BREAK,
      P_MAB,
      P_DATA,
      P_WAIT
   } frame_phase_type;

   // Frame predictor plus the queue of line results still owed by the block
   class frame_scoreboard;
      logic [7:0]         slot [0:STORE_SLOTS-1];
      frame_phase_type    phase;
      logic [17:0]        delay_left;
      logic [9:0]         next_slot;
      logic [7:0]         ticks_per_us;
      logic [9:0]         break_us;
      logic [7:0]         mab_us;
      dmxtx_pkg::rsp_type rsp_due[$];
      int unsigned        fails;

      function new();
         foreach (slot[i]) slot[i] = 8'h00;
         slot[0]      = dmxtx_pkg::START_CODE;
         phase        = P_IDLE;
         delay_left   = '0;
         next_slot    = '0;
         ticks_per_us = dmxtx_pkg::CYCLES_PER_US_RESET;
         break_us     = dmxtx_pkg::BREAK_LENGTH_US_RESET;
         mab_us       = dmxtx_pkg::MAB_LENGTH_US_RESET;
         fails        = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [9:0] value);
         case (idx)
            dmxtx_pkg::CSR_CYCLES_PER_US:   ticks_per_us = value[7:0];
            dmxtx_pkg::CSR_BREAK_LENGTH_US: break_us     = value;
            dmxtx_pkg::CSR_MAB_LENGTH_US:   mab_us       = value[7:0];
            default: ;
         endcase
      endfunction

      function logic [17:0] span(logic [9:0] us);
         return ticks_per_us * us;
      endfunction

      function bit chan_ok(logic [9:0] ch);
         return ch >= 1 && ch <= CHANNEL_COUNT;
      endfunction

      // Advance the frame state by one accepted word and queue its result
      function void note_word(dmxtx_pkg::req_type w);
         dmxtx_pkg::rsp_type r;
         r = '0;
         case (w.action)
            dmxtx_pkg::ACT_SET: if (chan_ok(w.channel)) slot[w.channel] = w.level;
            dmxtx_pkg::ACT_GET: if (chan_ok(w.channel)) r.read_level = slot[w.channel];
            dmxtx_pkg::ACT_SEND: begin
               if (phase == P_IDLE) begin
                  phase      = P_BREAK;
                  delay_left = span(break_us);
               end
            end
            dmxtx_pkg::ACT_TICK: begin
               case (phase)
                  P_BREAK: begin
                     if (delay_left <= 1) begin
                        phase      = P_MAB;
                        delay_left = span({2'b00, mab_us});
                     end else begin
                        delay_left--;
                     end
                  end
                  P_MAB: begin
                     if (delay_left <= 1) begin
                        phase      = P_DATA;
                        delay_left = '0;
                        next_slot  = '0;
                     end else begin
                        delay_left--;
                     end
                  end
                  P_DATA: begin
                     if (w.tx_ready) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = slot[next_slot];
                        next_slot++;
                        if (next_slot >= STORE_SLOTS) phase = P_WAIT;
                     end
                  end
                  P_WAIT: begin
                     if (w.tx_complete) begin
                        phase        = P_IDLE;
                        next_slot    = '0;
                        r.frame_done = 1'b1;
                     end
                  end
                  default: phase = P_IDLE;
               endcase
            end
            default: ;
         endcase
         r.line_mode = (phase == P_BREAK) ? dmxtx_pkg::LINE_LOW :
                       (phase == P_MAB)   ? dmxtx_pkg::LINE_HIGH : dmxtx_pkg::LINE_UART;
         r.busy_res  = (phase != P_IDLE);
         rsp_due.push_back(r);
      endfunction

      function void check_result(dmxtx_pkg::rsp_type got);
         dmxtx_pkg::rsp_type exp;
         if (rsp_due.size() == 0) begin
            fails++;
            if (fails <= 10)
               $display("mismatch: result with nothing pending, got %h", got);
            return;
         end
         exp = rsp_due.pop_front();
         if (got.line_mode  !== exp.line_mode  || got.tx_valid   !== exp.tx_valid ||
             got.tx_byte    !== exp.tx_byte    || got.read_level !== exp.read_level ||
             got.busy_res   !== exp.busy_res   || got.frame_done !== exp.frame_done) begin
            fails++;
            if (fails <= 10)
               $display({"mismatch: exp line=%0d txv=%0d byte=%h rd=%h busy=%0d done=%0d",
                         " | got line=%0d txv=%0d byte=%h rd=%h busy=%0d done=%0d"},
                        exp.line_mode, exp.tx_valid, exp.tx_byte, exp.read_level,
                        exp.busy_res, exp.frame_done,
                        got.line_mode, got.tx_valid, got.tx_byte, got.read_level,
                        got.busy_res, got.frame_done);
         end
      endfunction
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   dmxtx_pkg::req_type req_data  = '0;
   logic               csr_valid = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [9:0]         csr_data  = '0;
   logic               busy;
   logic               rsp_valid;
   dmxtx_pkg::rsp_type rsp_data;
   logic               csr_ready;

   int idle_pct = 33;
   frame_scoreboard sb;

   dmx512_frame_transmitter_core #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // result strobe, sampled at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_result(rsp_data);
   end

   function automatic dmxtx_pkg::req_type mk(logic [1:0] act, logic [9:0] ch,
                                             logic [7:0] lvl, logic rdy, logic cmp);
      dmxtx_pkg::req_type w;
      w.action      = act;
      w.channel     = ch;
      w.level       = lvl;
      w.tx_ready    = rdy;
      w.tx_complete = cmp;
      return w;
   endfunction

   // mostly ticks so frames run through; some out-of-range channels
   function automatic dmxtx_pkg::req_type rand_word();
      dmxtx_pkg::req_type w;
      int unsigned        pick;
      pick          = $urandom_range(0, 99);
      w.action      = (pick < 74) ? dmxtx_pkg::ACT_TICK :
                      (pick < 84) ? dmxtx_pkg::ACT_SET :
                      (pick < 93) ? dmxtx_pkg::ACT_GET : dmxtx_pkg::ACT_SEND;
      w.channel     = ($urandom_range(0, 6) == 0) ? 10'($urandom_range(0, 1023)) :
                      10'($urandom_range(1, CHANNEL_COUNT));
      w.level       = 8'($urandom);
      w.tx_ready    = ($urandom_range(0, 99) < 80);
      w.tx_complete = ($urandom_range(0, 99) < 30);
      return w;
   endfunction

   task automatic drive_word(input dmxtx_pkg::req_type w);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_word(w);
   endtask

   // hold off the sender until every pending result is back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.rsp_due.size() != 0);
   endtask

   // caller lowers csr_valid after the last write of a group
   task automatic csr_write(input logic [1:0] idx, input logic [9:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, value);
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero tick rate through the masked upper bits: every time acts as one tick
      csr_write(dmxtx_pkg::CSR_CYCLES_PER_US, 10'h100);
      csr_write(dmxtx_pkg::CSR_BREAK_LENGTH_US, 10'd3);
      csr_write(dmxtx_pkg::CSR_MAB_LENGTH_US, 10'd0);
      csr_valid <= 1'b0;

      // channel range edges on a cleared store
      drive_word(mk(dmxtx_pkg::ACT_GET, 10'd0, 8'h00, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_GET, 10'd1, 8'h00, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_SET, 10'd0, 8'hFF, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_SET, 10'd1, 8'hFF, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_SET, 10'd512, 8'hA5, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_SET, 10'd513, 8'h77, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_SET, 10'd1023, 8'h11, 1'b1, 1'b1));
      drive_word(mk(dmxtx_pkg::ACT_GET, 10'd1, 8'h00, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_GET, 10'd512, 8'h00, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_GET, 10'd513, 8'h00, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_GET, 10'd1023, 8'h00, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_GET, 10'd0, 8'h00, 1'b0, 1'b0));
      // idle tick keeps the line with the UART
      drive_word(mk(dmxtx_pkg::ACT_TICK, 10'd0, 8'h00, 1'b1, 1'b1));
      // send, then a second send while the frame runs
      drive_word(mk(dmxtx_pkg::ACT_SEND, 10'd0, 8'h00, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_SEND, 10'd0, 8'h00, 1'b1, 1'b1));
      drive_word(mk(dmxtx_pkg::ACT_TICK, 10'd0, 8'h00, 1'b1, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_TICK, 10'd0, 8'h00, 1'b1, 1'b0));
      // update a slot not yet sent
      drive_word(mk(dmxtx_pkg::ACT_SET, 10'd2, 8'h5A, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_TICK, 10'd0, 8'h00, 1'b0, 1'b1));
      drive_word(mk(dmxtx_pkg::ACT_TICK, 10'd0, 8'h00, 1'b1, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_TICK, 10'd0, 8'h00, 1'b1, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_TICK, 10'd0, 8'h00, 1'b1, 1'b0));
      // slot already sent, new level only shows on the next frame
      drive_word(mk(dmxtx_pkg::ACT_SET, 10'd1, 8'h00, 1'b0, 1'b0));
      drive_word(mk(dmxtx_pkg::ACT_GET, 10'd2, 8'h00, 1'b0, 1'b0));

      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: begin
               csr_write(dmxtx_pkg::CSR_CYCLES_PER_US, 10'd1);
               csr_write(dmxtx_pkg::CSR_BREAK_LENGTH_US, 10'd1);
               csr_write(dmxtx_pkg::CSR_MAB_LENGTH_US, 10'd1);
            end
            1: begin
               // top tick rate through the masked upper bits
               csr_write(dmxtx_pkg::CSR_CYCLES_PER_US, 10'h3FF);
               csr_write(dmxtx_pkg::CSR_BREAK_LENGTH_US, 10'd1);
               csr_write(dmxtx_pkg::CSR_MAB_LENGTH_US, 10'h201);
            end
            2: begin
               csr_write(dmxtx_pkg::CSR_CYCLES_PER_US, 10'd1);
               csr_write(dmxtx_pkg::CSR_BREAK_LENGTH_US, 10'd1023);
               csr_write(dmxtx_pkg::CSR_MAB_LENGTH_US, 10'd255);
            end
            3: begin
               csr_write(dmxtx_pkg::CSR_CYCLES_PER_US, 10'd0);
               csr_write(dmxtx_pkg::CSR_BREAK_LENGTH_US, 10'd0);
               csr_write(dmxtx_pkg::CSR_MAB_LENGTH_US, 10'd0);
            end
            4: begin
               csr_write(dmxtx_pkg::CSR_CYCLES_PER_US, 10'd2);
               csr_write(dmxtx_pkg::CSR_BREAK_LENGTH_US, 10'($urandom_range(1, 8)));
               csr_write(dmxtx_pkg::CSR_MAB_LENGTH_US, 10'($urandom_range(1, 8)));
            end
            default: begin
               csr_write(dmxtx_pkg::CSR_CYCLES_PER_US, 10'd1);
               csr_write(dmxtx_pkg::CSR_BREAK_LENGTH_US, 10'd2);
               csr_write(dmxtx_pkg::CSR_MAB_LENGTH_US, 10'd1);
            end
         endcase
         csr_write(CSR_SPARE, 10'($urandom));
         csr_valid <= 1'b0;
         idle_pct = (p < 2) ? 33 : (p < 4) ? 50 : 0;

         for (int n = 0; n < 258; n++) begin
            drive_word(rand_word());
            if ($urandom_range(0, 99) == 0) drain();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.fails == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

### files.f
hdl/dmxtx_pkg.sv
hdl/dmxtx_front.sv
hdl/dmxtx_back.sv
hdl/dmx512_frame_transmitter_core.sv
dv/dmx512_frame_transmitter_core_tb.sv
